FILE: hw/rtl/hus_pkg.sv
`timescale 1ns / 1ps

package hus_pkg;

    // Result status codes; the nonzero ones but ST_LONG double as the sticky fault code.
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SCHEME = 3'd1,
        ST_HOST   = 3'd2,
        ST_PORT   = 3'd3,
        ST_LONG   = 3'd4
    } t_status;

    // Parse phases of the character stream.
    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_HOSTSEL = 3'd1,
        PH_HOST    = 3'd2,
        PH_V6      = 3'd3,
        PH_AFTERV6 = 3'd4,
        PH_PORT    = 3'd5,
        PH_PATH    = 3'd6,
        PH_STOP    = 3'd7
    } t_phase;

    // One finished result.
    typedef struct packed {
        t_status     status;
        logic [7:0]  host_pos;
        logic [7:0]  host_length;
        logic [15:0] port_value;
        logic        port_given;
        logic [7:0]  port_pos;
        logic [7:0]  port_length;
        logic [7:0]  path_pos;
        logic [7:0]  path_length;
        logic        path_is_default;
    } t_result;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [15:0] DEFAULT_PORT   = 16'd443;
    localparam logic [19:0] PORT_MAX       = 20'd65535;
    localparam logic [7:0]  HOST_OFS_PLAIN = 8'd8;
    localparam logic [7:0]  HOST_OFS_V6    = 8'd9;
    localparam int          MIN_URI_LEN    = 9;

    // Expected prefix character at each of the first eight positions.
    function automatic logic [7:0] scheme_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h68; // h
            3'd1:    c = 8'h74; // t
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h70; // p
            3'd4:    c = 8'h73; // s
            3'd5:    c = 8'h3A; // :
            3'd6:    c = 8'h2F; // /
            default: c = 8'h2F; // /
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/hus_if.sv
`timescale 1ns / 1ps

// Character request channel.
interface hus_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

// Result request channel.
interface hus_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  host_pos;
    logic [7:0]  host_length;
    logic [15:0] port_value;
    logic        port_given;
    logic [7:0]  port_pos;
    logic [7:0]  port_length;
    logic [7:0]  path_pos;
    logic [7:0]  path_length;
    logic        path_is_default;

    modport source (output valid, output status, output host_pos, output host_length,
                    output port_value, output port_given, output port_pos,
                    output port_length, output path_pos, output path_length,
                    output path_is_default, input ready);
    modport sink   (input valid, input status, input host_pos, input host_length,
                    input port_value, input port_given, input port_pos,
                    input port_length, input path_pos, input path_length,
                    input path_is_default, output ready);
endinterface

FILE: hw/rtl/https_uri_splitter.sv
`timescale 1ns / 1ps

// Channel    Direction  Payload                                 Request
// i_char     in         ch[7:0], last                           one URI character
// o_result   out        status, host/port/path offsets+lengths  one per URI, on last
//
// One character is taken every cycle unless a last one stalls on a full result;
// the state update is a single pass of logic between the input register and
// the parse state registers. A result is registered as its last character leaves.
// A stalled result only holds back a following last character; other
// characters keep flowing. Reset is synchronous and clears all control state.
// Latency and rate do not depend on MAX_URI_LEN.

module https_uri_splitter
    import hus_pkg::*;
#(
    parameter int MAX_URI_LEN = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hus_char_if.sink     i_char,
    hus_result_if.source o_result
);

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_res;
    t_result    w_res;
    logic       w_advance;

    // The held character moves on unless it closes a URI and the result is full.
    assign w_advance    = r_in_valid && (!r_in_last || !r_out_valid || o_result.ready);
    assign i_char.ready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready) begin
            r_in_ch   <= i_char.ch;
            r_in_last <= i_char.last;
        end
    end

    hus_parser #(
        .MAX_URI_LEN (MAX_URI_LEN)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_ch     (r_in_ch),
        .i_last   (r_in_last),
        .o_result (w_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_res <= w_res;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.status          = r_res.status;
    assign o_result.host_pos        = r_res.host_pos;
    assign o_result.host_length     = r_res.host_length;
    assign o_result.port_value      = r_res.port_value;
    assign o_result.port_given      = r_res.port_given;
    assign o_result.port_pos        = r_res.port_pos;
    assign o_result.port_length     = r_res.port_length;
    assign o_result.path_pos        = r_res.path_pos;
    assign o_result.path_length     = r_res.path_length;
    assign o_result.path_is_default = r_res.path_is_default;

    // A character that does not close a URI is never held back.
    a_mid_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_in_last |-> w_advance)
        else $error("mid-URI character stalled");

    // A failed URI reports nothing but its status.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.status != ST_OK |->
            r_res.port_given == 1'b0 && r_res.host_length == 8'd0 &&
            r_res.path_pos == 8'd0 && r_res.port_value == 16'd0)
        else $error("fields set on a failed result");

    // Without an explicit port the default port is reported.
    a_default_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.status == ST_OK && !r_res.port_given |->
            r_res.port_value == DEFAULT_PORT && r_res.port_length == 8'd0)
        else $error("default port missing");

    // A new result is loaded only when the old one is gone or taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in_last |-> !r_out_valid || o_result.ready)
        else $error("pending result overwritten");

endmodule

FILE: hw/rtl/hus_parser.sv
`timescale 1ns / 1ps

module hus_parser
    import hus_pkg::*;
#(
    parameter int MAX_URI_LEN = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output t_result    o_result
);

    localparam int PosW = $clog2(MAX_URI_LEN + 1);
    localparam logic [PosW-1:0] MaxPos = PosW'(MAX_URI_LEN);
    localparam logic [PosW-1:0] MinLen = PosW'(MIN_URI_LEN);

    t_phase          r_phase,      n_phase;
    logic [PosW-1:0] r_position,   n_position;
    logic            r_host_v6,    n_host_v6;
    logic [PosW-1:0] r_host_count, n_host_count;
    logic [15:0]     r_port_acc,   n_port_acc;
    logic [7:0]      r_port_start, n_port_start;
    logic [PosW-1:0] r_port_count, n_port_count;
    logic [7:0]      r_path_start, n_path_start;
    logic [PosW-1:0] r_path_count, n_path_count;
    t_status         r_fault,      n_fault;
    logic            r_port_seen,  n_port_seen;
    logic            r_path_seen,  n_path_seen;
    logic            r_overflow,   n_overflow;

    logic        w_host_end;
    logic        w_path_end;
    logic        w_digit;
    logic [19:0] w_acc_next;

    assign w_host_end = (i_ch == CH_COLON) || (i_ch == CH_SLASH) ||
                        (i_ch == CH_QUEST) || (i_ch == CH_HASH);
    assign w_path_end = (i_ch == CH_SLASH) || (i_ch == CH_QUEST) || (i_ch == CH_HASH);
    assign w_digit    = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    // Decimal accumulate as shifts and adds: acc * 8 + acc * 2 + digit.
    assign w_acc_next = ({4'b0, r_port_acc} << 3) + ({4'b0, r_port_acc} << 1) +
                        {16'b0, i_ch[3:0]};

    // Next parse state for the character in hand.
    always_comb begin
        n_phase      = r_phase;
        n_position   = r_position;
        n_host_v6    = r_host_v6;
        n_host_count = r_host_count;
        n_port_acc   = r_port_acc;
        n_port_start = r_port_start;
        n_port_count = r_port_count;
        n_path_start = r_path_start;
        n_path_count = r_path_count;
        n_fault      = r_fault;
        n_port_seen  = r_port_seen;
        n_path_seen  = r_path_seen;
        n_overflow   = r_overflow;

        if (r_position == MaxPos) begin
            // Characters past the length limit only mark the overflow.
            n_overflow = 1'b1;
        end else begin
            n_position = r_position + 1'b1;
            case (r_phase)
                PH_PREFIX: begin
                    if (i_ch != scheme_char(r_position[2:0])) begin
                        n_fault = ST_SCHEME;
                        n_phase = PH_STOP;
                    end else if (r_position[2:0] == 3'd7) begin
                        n_phase = PH_HOSTSEL;
                    end
                end
                PH_HOSTSEL: begin
                    if (i_ch == CH_LBRACK) begin
                        n_host_v6 = 1'b1;
                        n_phase   = PH_V6;
                    end else if (w_host_end) begin
                        n_fault = ST_HOST;
                        n_phase = PH_STOP;
                    end else begin
                        n_host_v6    = 1'b0;
                        n_host_count = PosW'(1);
                        n_phase      = PH_HOST;
                    end
                end
                PH_HOST, PH_AFTERV6: begin
                    if (r_phase == PH_HOST && !w_host_end) begin
                        n_host_count = r_host_count + 1'b1;
                    end else if (i_ch == CH_COLON) begin
                        n_port_seen  = 1'b1;
                        n_port_start = 8'(r_position) + 8'd1;
                        n_phase      = PH_PORT;
                    end else begin
                        n_path_start = 8'(r_position);
                        n_path_seen  = 1'b1;
                        if (i_ch == CH_HASH) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_path_count = PosW'(1);
                            n_phase      = PH_PATH;
                        end
                    end
                end
                PH_V6: begin
                    if (i_ch == CH_RBRACK) begin
                        if (r_host_count == '0) begin
                            n_fault = ST_HOST;
                            n_phase = PH_STOP;
                        end else begin
                            n_phase = PH_AFTERV6;
                        end
                    end else begin
                        n_host_count = r_host_count + 1'b1;
                    end
                end
                PH_PORT: begin
                    if (w_path_end) begin
                        if (r_port_acc == '0) begin
                            n_fault = ST_PORT;
                            n_phase = PH_STOP;
                        end else begin
                            n_path_start = 8'(r_position);
                            n_path_seen  = 1'b1;
                            if (i_ch == CH_HASH) begin
                                n_phase = PH_STOP;
                            end else begin
                                n_path_count = PosW'(1);
                                n_phase      = PH_PATH;
                            end
                        end
                    end else if (w_digit) begin
                        n_port_acc   = w_acc_next[15:0];
                        n_port_count = r_port_count + 1'b1;
                        if (w_acc_next > PORT_MAX) begin
                            n_fault = ST_PORT;
                            n_phase = PH_STOP;
                        end
                    end else begin
                        n_fault = ST_PORT;
                        n_phase = PH_STOP;
                    end
                end
                PH_PATH: begin
                    if (i_ch == CH_HASH) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_path_count = r_path_count + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result as seen after this character, used when it is the last one.
    always_comb begin
        t_status st;
        if (n_overflow) begin
            st = ST_LONG;
        end else if (n_position < MinLen || n_fault == ST_SCHEME) begin
            st = ST_SCHEME;
        end else if (n_fault != ST_OK) begin
            st = n_fault;
        end else if (n_phase == PH_V6 || n_phase == PH_HOSTSEL || n_host_count == '0) begin
            st = ST_HOST;
        end else if (n_phase == PH_PORT && n_port_acc == '0) begin
            st = ST_PORT;
        end else begin
            st = ST_OK;
        end

        o_result        = '0;
        o_result.status = st;
        if (st == ST_OK) begin
            o_result.host_pos    = n_host_v6 ? HOST_OFS_V6 : HOST_OFS_PLAIN;
            o_result.host_length = 8'(n_host_count);
            o_result.port_value  = n_port_seen ? n_port_acc : DEFAULT_PORT;
            o_result.port_given  = n_port_seen;
            o_result.port_pos    = n_port_seen ? n_port_start : 8'd0;
            o_result.port_length = n_port_seen ? 8'(n_port_count) : 8'd0;
            if (n_path_seen) begin
                o_result.path_pos        = n_path_start;
                o_result.path_length     = 8'(n_path_count);
                o_result.path_is_default = (n_path_count == '0);
            end else begin
                // No path at all: it begins at the end of the URI.
                o_result.path_pos        = 8'(n_position);
                o_result.path_length     = 8'd0;
                o_result.path_is_default = 1'b1;
            end
        end
    end

    // State registers; the last character returns everything to the start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase      <= PH_PREFIX;
            r_position   <= '0;
            r_host_v6    <= 1'b0;
            r_host_count <= '0;
            r_port_acc   <= '0;
            r_port_start <= '0;
            r_port_count <= '0;
            r_path_start <= '0;
            r_path_count <= '0;
            r_fault      <= ST_OK;
            r_port_seen  <= 1'b0;
            r_path_seen  <= 1'b0;
            r_overflow   <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_position   <= n_position;
            r_host_v6    <= n_host_v6;
            r_host_count <= n_host_count;
            r_port_acc   <= n_port_acc;
            r_port_start <= n_port_start;
            r_port_count <= n_port_count;
            r_path_start <= n_path_start;
            r_path_count <= n_path_count;
            r_fault      <= n_fault;
            r_port_seen  <= n_port_seen;
            r_path_seen  <= n_path_seen;
            r_overflow   <= n_overflow;
        end
    end

endmodule
